// ===== hdl/bdb_pkg.sv =====
package bdb_pkg;

    localparam int DIM_W              = 11;
    localparam int PIX_W              = 8;
    localparam int ROW_W              = 10;
    localparam int RGB_W              = 3 * PIX_W;
    localparam int DIM_LIMIT          = 1024;
    localparam int MAX_LINE_WIDTH_DEF = 1024;
    localparam int CFG_ADDR_W         = 3;
    localparam int CHANNELS           = 3;

    localparam logic [DIM_W-1:0] SIZE_RESET  = 11'd64;
    localparam logic [PIX_W-1:0] LEVEL_RESET = 8'd127;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_SOURCE_WIDTH  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SOURCE_HEIGHT = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_TARGET_WIDTH  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_TARGET_HEIGHT = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_BINARIZE_LVL  = 3'd4;

    // lerp phases inside a lane
    localparam logic [1:0] PH_LEFT   = 2'd0;
    localparam logic [1:0] PH_RIGHT  = 2'd1;
    localparam logic [1:0] PH_ACROSS = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_ROW,
        ST_YMAP,
        ST_XMAP,
        ST_LERP,
        ST_EMIT,
        ST_CSTEP,
        ST_STORE,
        ST_RMAP
    } state_t;

    typedef struct packed {
        logic             start;
        logic [DIM_W-1:0] t;
        logic [DIM_W-1:0] s;
        logic [DIM_W-1:0] d;
    } map_req_t;

    typedef struct packed {
        logic             done;
        logic [DIM_W-1:0] q;
        logic [DIM_W-1:0] rem;
        logic [DIM_W-1:0] trig;
    } map_rsp_t;

    typedef struct packed {
        logic             start;
        logic [DIM_W-1:0] ny;
        logic [DIM_W-1:0] th;
        logic [DIM_W-1:0] nx;
        logic [DIM_W-1:0] tw;
    } lerp_ctrl_t;

    // zero counts as one, large values saturate
    function automatic logic [DIM_W-1:0] clamp_size(input logic [DIM_W-1:0] v,
                                                    input logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] r;
        if (v == '0)
        begin
            r = 11'd1;
        end
        else if (v > hi)
        begin
            r = hi;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ===== hdl/bdb_if.sv =====
interface bdb_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic       frame_start;
    modport source (output valid, red_in, green_in, blue_in, frame_start, input ready);
    modport sink (input valid, red_in, green_in, blue_in, frame_start, output ready);
endinterface

interface bdb_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       pattern_bit;
    logic       frame_end;
    modport source (output valid, red_out, green_out, blue_out, pattern_bit, frame_end,
                    input ready);
    modport sink (input valid, red_out, green_out, blue_out, pattern_bit, frame_end,
                  output ready);
endinterface

interface bdb_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  addr;
    logic [10:0] data;
    modport source (output valid, addr, data, input ready);
    modport sink (input valid, addr, data, output ready);
endinterface

// ===== hdl/bdb_ram.sv =====
module bdb_ram #(
    parameter int WIDTH = bdb_pkg::RGB_W,
    parameter int DEPTH = bdb_pkg::MAX_LINE_WIDTH_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/bdb_axis_map.sv =====
module bdb_axis_map (
    input  logic              clk,
    input  logic              rst_n,
    input  bdb_pkg::map_req_t req,
    output bdb_pkg::map_rsp_t rsp
);

    localparam int W = bdb_pkg::DIM_W;

    logic           load_reg;
    logic           busy_reg;
    logic           done_reg;
    logic [3:0]     cnt_reg;
    logic [2*W-1:0] prod_reg;
    logic [W-1:0]   d_reg;
    logic [W-1:0]   s_reg;
    logic [W-1:0]   rem_reg;
    logic [W-1:0]   q_reg;

    logic [W:0]     trial;
    logic           ge;
    logic [W-1:0]   rem_next;
    logic [W-1:0]   q_next;
    logic [W-1:0]   q_inc;
    logic [W-1:0]   s_m1;

    // restoring divide, one quotient bit per cycle
    always_comb
    begin
        trial    = {rem_reg, q_reg[W-1]};
        ge       = trial >= {1'b0, d_reg};
        rem_next = ge ? W'(trial - {1'b0, d_reg}) : trial[W-1:0];
        q_next   = {q_reg[W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_reg <= 1'b0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                load_reg <= 1'b1;
                busy_reg <= 1'b0;
            end
            else if (load_reg)
            begin
                load_reg <= 1'b0;
                busy_reg <= 1'b1;
                cnt_reg  <= 4'(W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 4'd1;
                if (cnt_reg == 4'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            prod_reg <= {{W{1'b0}}, req.t} * {{W{1'b0}}, req.s};
            d_reg    <= req.d;
            s_reg    <= req.s;
        end
        else if (load_reg)
        begin
            // product stays below d * 2^W, so the upper half is a valid remainder
            rem_reg <= prod_reg[2*W-1:W];
            q_reg   <= prod_reg[W-1:0];
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

    // trigger: exact hit stays, otherwise next index clamped to the edge
    assign q_inc = q_reg + 11'd1;
    assign s_m1  = s_reg - 11'd1;

    always_comb
    begin
        rsp.done = done_reg;
        rsp.q    = q_reg;
        rsp.rem  = rem_reg;
        if (rem_reg == '0)
        begin
            rsp.trig = q_reg;
        end
        else if (q_inc < s_m1)
        begin
            rsp.trig = q_inc;
        end
        else
        begin
            rsp.trig = s_m1;
        end
    end

endmodule

// ===== hdl/bdb_lane.sv =====
module bdb_lane (
    input  logic                clk,
    input  logic                rst_n,
    input  bdb_pkg::lerp_ctrl_t ctrl,
    input  logic [7:0]          p11,
    input  logic [7:0]          p12,
    input  logic [7:0]          p21,
    input  logic [7:0]          p22,
    output logic                done,
    output logic [7:0]          res
);

    localparam int W = bdb_pkg::DIM_W;
    localparam int P = bdb_pkg::PIX_W;

    logic [1:0]   phase_reg;
    logic         load_reg;
    logic         busy_reg;
    logic         done_reg;
    logic [3:0]   cnt_reg;
    logic [W-1:0] rem_reg;
    logic [P-1:0] q_reg;
    logic [P-1:0] ya_reg;
    logic [P-1:0] yb_reg;
    logic [P-1:0] res_reg;

    logic [P-1:0]         a_sel;
    logic [P-1:0]         b_sel;
    logic [W-1:0]         num_sel;
    logic [W-1:0]         den_sel;
    logic signed [P+1:0]  diff;
    logic [W+P-1:0]       base;
    logic signed [20:0]   term;
    logic signed [20:0]   vsum;
    logic [W:0]           trial;
    logic                 ge;
    logic [W-1:0]         rem_next;
    logic [P-1:0]         q_next;

    always_comb
    begin
        case (phase_reg)
            bdb_pkg::PH_LEFT:
            begin
                a_sel   = p11;
                b_sel   = p12;
                num_sel = ctrl.ny;
                den_sel = ctrl.th;
            end
            bdb_pkg::PH_RIGHT:
            begin
                a_sel   = p21;
                b_sel   = p22;
                num_sel = ctrl.ny;
                den_sel = ctrl.th;
            end
            default:
            begin
                a_sel   = ya_reg;
                b_sel   = yb_reg;
                num_sel = ctrl.nx;
                den_sel = ctrl.tw;
            end
        endcase
    end

    // a*den + num*(b-a), never negative and below 256*den
    always_comb
    begin
        diff  = $signed({2'b00, b_sel}) - $signed({2'b00, a_sel});
        base  = {{W{1'b0}}, a_sel} * {{P{1'b0}}, den_sel};
        term  = $signed({10'd0, num_sel}) * $signed({{11{diff[P+1]}}, diff});
        vsum  = $signed({2'b00, base}) + term;
        trial    = {rem_reg, q_reg[P-1]};
        ge       = trial >= {1'b0, den_sel};
        rem_next = ge ? W'(trial - {1'b0, den_sel}) : trial[W-1:0];
        q_next   = {q_reg[P-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= bdb_pkg::PH_LEFT;
            load_reg  <= 1'b0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.start)
            begin
                phase_reg <= bdb_pkg::PH_LEFT;
                load_reg  <= 1'b1;
                busy_reg  <= 1'b0;
            end
            else if (load_reg)
            begin
                load_reg <= 1'b0;
                busy_reg <= 1'b1;
                cnt_reg  <= 4'(P);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 4'd1;
                if (cnt_reg == 4'd1)
                begin
                    busy_reg <= 1'b0;
                    if (phase_reg == bdb_pkg::PH_ACROSS)
                    begin
                        done_reg <= 1'b1;
                    end
                    else
                    begin
                        phase_reg <= phase_reg + 2'd1;
                        load_reg  <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_reg)
        begin
            rem_reg <= {1'b0, vsum[2*P+1:P]};
            q_reg   <= vsum[P-1:0];
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            q_reg   <= q_next;
            if (cnt_reg == 4'd1)
            begin
                case (phase_reg)
                    bdb_pkg::PH_LEFT:  ya_reg  <= q_next;
                    bdb_pkg::PH_RIGHT: yb_reg  <= q_next;
                    default:           res_reg <= q_next;
                endcase
            end
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

// ===== hdl/bdb_merge.sv =====
module bdb_merge (
    input  logic [7:0] red,
    input  logic [7:0] green,
    input  logic [7:0] blue,
    input  logic [7:0] level,
    output logic       pattern
);

    logic [9:0] sum;
    logic [9:0] thresh;

    // floor(sum/3) > level  <=>  sum > 3*level + 2
    assign sum     = {2'b00, red} + {2'b00, green} + {2'b00, blue};
    assign thresh  = 10'({2'b00, level} * 10'd3) + 10'd2;
    assign pattern = sum > thresh;

endmodule

// ===== hdl/bilinear_downscale_binarize.sv =====
// channel  | dir | handshake             | payload
// pix_in   | in  | valid/ready           | red_in, green_in, blue_in, frame_start
// res_out  | out | valid/ready           | red_out, green_out, blue_out, pattern_bit, frame_end
// cfg      | in  | valid/ready (ready=1) | addr (register index), data
//
// one source pixel is in flight at a time; each position map is a serial divide
// and the three channel lanes each run three serial lerp divides
// per item: the line store is read, the target row is mapped unless past the last target row,
// a triggering row maps the target column, a completed destination pixel runs the lanes and
// is emitted, further target columns are stepped past, and target rows are checked at line end
// rst_n is asynchronous; it clears counters, left and upper-left pixel history and config to defaults
// a result waiting on res_out stalls the next emission, and input acceptance waits behind it
module bilinear_downscale_binarize #(
    parameter int MAX_LINE_WIDTH = bdb_pkg::MAX_LINE_WIDTH_DEF
) (
    input logic         clk,
    input logic         rst_n,
    bdb_pix_if.sink     pix_in,
    bdb_res_if.source   res_out,
    bdb_cfg_if.sink     cfg
);

    localparam int W     = bdb_pkg::DIM_W;
    localparam int P     = bdb_pkg::PIX_W;
    localparam int RW    = bdb_pkg::ROW_W;
    localparam int LIM   = (MAX_LINE_WIDTH < bdb_pkg::DIM_LIMIT) ? MAX_LINE_WIDTH
                                                                 : bdb_pkg::DIM_LIMIT;
    localparam int COL_W = (LIM > 1) ? $clog2(LIM) : 1;
    localparam logic [W-1:0] LIM_SIZE = W'(LIM);
    localparam logic [W-1:0] DIM_MAX  = W'(bdb_pkg::DIM_LIMIT);

    // configuration
    logic [W-1:0] sw_cfg_reg;
    logic [W-1:0] sh_cfg_reg;
    logic [W-1:0] tw_cfg_reg;
    logic [W-1:0] th_cfg_reg;
    logic [P-1:0] level_reg;
    logic [W-1:0] sw;
    logic [W-1:0] sh;
    logic [W-1:0] tw;
    logic [W-1:0] th;

    // sequencer and position state
    bdb_pkg::state_t state_reg, state_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [RW-1:0]    row_reg, row_next;
    logic [W-1:0]     ntc_reg, ntc_next;
    logic [W-1:0]     ntr_reg, ntr_next;
    logic             first_reg, first_next;
    logic             out_valid_reg, out_valid_next;

    // pixel history and mapping results
    logic [3*P-1:0] cur_reg;
    logic [3*P-1:0] up_reg;
    logic [3*P-1:0] left_reg;
    logic [3*P-1:0] upl_reg;
    logic [W-1:0]   ny_reg;
    logic [W-1:0]   nx_reg;
    logic           oy_reg;
    logic           ox_reg;
    logic [W-1:0]   xtrig_reg;

    // result register
    logic [P-1:0] red_reg;
    logic [P-1:0] green_reg;
    logic [P-1:0] blue_reg;
    logic         pattern_reg;
    logic         frame_end_reg;

    // strobes
    logic take_cur;
    logic take_up;
    logic take_y;
    logic take_x;
    logic shift_pix;
    logic load_out;
    logic ram_re;
    logic ram_we;
    logic lane_go;

    bdb_pkg::map_req_t   map_req;
    bdb_pkg::map_rsp_t   map_rsp;
    bdb_pkg::lerp_ctrl_t lane_ctrl;

    logic [3*P-1:0] ram_rdata;
    logic [W-1:0]   c_ext;
    logic [W-1:0]   r_ext;
    logic [W-1:0]   ntc_inc;
    logic [W-1:0]   ntr_inc;
    logic [3*P-1:0] c11;
    logic [3*P-1:0] c12;
    logic [3*P-1:0] c21;
    logic [P-1:0]   lane_res [bdb_pkg::CHANNELS];
    logic [bdb_pkg::CHANNELS-1:0] lane_done;
    logic           pattern;

    // effective sizes
    assign sw = bdb_pkg::clamp_size(sw_cfg_reg, LIM_SIZE);
    assign sh = bdb_pkg::clamp_size(sh_cfg_reg, DIM_MAX);
    assign tw = bdb_pkg::clamp_size(tw_cfg_reg, DIM_MAX);
    assign th = bdb_pkg::clamp_size(th_cfg_reg, DIM_MAX);

    assign c_ext   = W'(col_reg);
    assign r_ext   = W'(row_reg);
    assign ntc_inc = ntc_reg + 11'd1;
    assign ntr_inc = ntr_reg + 11'd1;

    // configuration port, always ready
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sw_cfg_reg <= bdb_pkg::SIZE_RESET;
            sh_cfg_reg <= bdb_pkg::SIZE_RESET;
            tw_cfg_reg <= bdb_pkg::SIZE_RESET;
            th_cfg_reg <= bdb_pkg::SIZE_RESET;
            level_reg  <= bdb_pkg::LEVEL_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.addr)
                bdb_pkg::CFG_SOURCE_WIDTH:  sw_cfg_reg <= cfg.data;
                bdb_pkg::CFG_SOURCE_HEIGHT: sh_cfg_reg <= cfg.data;
                bdb_pkg::CFG_TARGET_WIDTH:  tw_cfg_reg <= cfg.data;
                bdb_pkg::CFG_TARGET_HEIGHT: th_cfg_reg <= cfg.data;
                bdb_pkg::CFG_BINARIZE_LVL:  level_reg  <= cfg.data[P-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // sequencer: next state and strobes
    always_comb
    begin
        state_next     = state_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        ntc_next       = ntc_reg;
        ntr_next       = ntr_reg;
        first_next     = first_reg;
        out_valid_next = out_valid_reg && !res_out.ready;
        take_cur       = 1'b0;
        take_up        = 1'b0;
        take_y         = 1'b0;
        take_x         = 1'b0;
        shift_pix      = 1'b0;
        load_out       = 1'b0;
        ram_re         = 1'b0;
        ram_we         = 1'b0;
        lane_go        = 1'b0;
        pix_in.ready   = 1'b0;
        map_req        = '0;

        case (state_reg)
            bdb_pkg::ST_IDLE:
            begin
                pix_in.ready = 1'b1;
                if (pix_in.valid)
                begin
                    take_cur = 1'b1;
                    // frame start restarts source position and target counters
                    if (pix_in.frame_start)
                    begin
                        col_next = '0;
                        row_next = '0;
                        ntc_next = '0;
                        ntr_next = '0;
                    end
                    state_next = bdb_pkg::ST_READ;
                end
            end
            bdb_pkg::ST_READ:
            begin
                ram_re     = 1'b1;
                state_next = bdb_pkg::ST_ROW;
            end
            bdb_pkg::ST_ROW:
            begin
                take_up = 1'b1;
                if (ntr_reg < th)
                begin
                    map_req    = '{start: 1'b1, t: ntr_reg, s: sh, d: th};
                    state_next = bdb_pkg::ST_YMAP;
                end
                else
                begin
                    state_next = bdb_pkg::ST_STORE;
                end
            end
            bdb_pkg::ST_YMAP:
            begin
                if (map_rsp.done)
                begin
                    take_y = 1'b1;
                    if (r_ext == map_rsp.trig && ntc_reg < tw)
                    begin
                        map_req    = '{start: 1'b1, t: ntc_reg, s: sw, d: tw};
                        first_next = 1'b1;
                        state_next = bdb_pkg::ST_XMAP;
                    end
                    else
                    begin
                        state_next = bdb_pkg::ST_STORE;
                    end
                end
            end
            bdb_pkg::ST_XMAP:
            begin
                if (map_rsp.done)
                begin
                    take_x     = first_reg;
                    first_next = 1'b0;
                    // only the current target column can fire on this pixel
                    if (first_reg && c_ext == map_rsp.trig)
                    begin
                        lane_go    = 1'b1;
                        state_next = bdb_pkg::ST_LERP;
                    end
                    else
                    begin
                        state_next = bdb_pkg::ST_CSTEP;
                    end
                end
            end
            bdb_pkg::ST_LERP:
            begin
                if (&lane_done)
                begin
                    state_next = bdb_pkg::ST_EMIT;
                end
            end
            bdb_pkg::ST_EMIT:
            begin
                if (!out_valid_reg || res_out.ready)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = bdb_pkg::ST_CSTEP;
                end
            end
            bdb_pkg::ST_CSTEP:
            begin
                // step past every target column whose trigger is behind us
                if (xtrig_reg <= c_ext)
                begin
                    ntc_next = ntc_inc;
                    if (ntc_inc < tw)
                    begin
                        map_req    = '{start: 1'b1, t: ntc_inc, s: sw, d: tw};
                        state_next = bdb_pkg::ST_XMAP;
                    end
                    else
                    begin
                        state_next = bdb_pkg::ST_STORE;
                    end
                end
                else
                begin
                    state_next = bdb_pkg::ST_STORE;
                end
            end
            bdb_pkg::ST_STORE:
            begin
                ram_we    = 1'b1;
                shift_pix = 1'b1;
                state_next = bdb_pkg::ST_IDLE;
                if (c_ext >= sw - 11'd1)
                begin
                    // end of source line
                    col_next = '0;
                    ntc_next = '0;
                    if (r_ext >= sh - 11'd1)
                    begin
                        row_next = '0;
                        ntr_next = '0;
                    end
                    else
                    begin
                        row_next = row_reg + RW'(1);
                        if (ntr_reg < th)
                        begin
                            map_req    = '{start: 1'b1, t: ntr_reg, s: sh, d: th};
                            state_next = bdb_pkg::ST_RMAP;
                        end
                    end
                end
                else
                begin
                    col_next = col_reg + COL_W'(1);
                end
            end
            bdb_pkg::ST_RMAP:
            begin
                // row_reg already holds the next row, so "trigger <= old row" is "<"
                if (map_rsp.done)
                begin
                    if (map_rsp.trig < r_ext)
                    begin
                        ntr_next = ntr_inc;
                        if (ntr_inc < th)
                        begin
                            map_req = '{start: 1'b1, t: ntr_inc, s: sh, d: th};
                        end
                        else
                        begin
                            state_next = bdb_pkg::ST_IDLE;
                        end
                    end
                    else
                    begin
                        state_next = bdb_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = bdb_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bdb_pkg::ST_IDLE;
            col_reg       <= '0;
            row_reg       <= '0;
            ntc_reg       <= '0;
            ntr_reg       <= '0;
            first_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            left_reg      <= '0;
            upl_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            ntc_reg       <= ntc_next;
            ntr_reg       <= ntr_next;
            first_reg     <= first_next;
            out_valid_reg <= out_valid_next;
            if (shift_pix)
            begin
                upl_reg  <= up_reg;
                left_reg <= cur_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (take_cur)
        begin
            cur_reg <= {pix_in.red_in, pix_in.green_in, pix_in.blue_in};
        end
        if (take_up)
        begin
            up_reg <= ram_rdata;
        end
        if (take_y)
        begin
            ny_reg <= map_rsp.rem;
            oy_reg <= map_rsp.trig != map_rsp.q;
        end
        if (take_x)
        begin
            nx_reg <= map_rsp.rem;
            ox_reg <= map_rsp.trig != map_rsp.q;
        end
        if (state_reg == bdb_pkg::ST_XMAP && map_rsp.done)
        begin
            xtrig_reg <= map_rsp.trig;
        end
        if (load_out)
        begin
            red_reg       <= lane_res[0];
            green_reg     <= lane_res[1];
            blue_reg      <= lane_res[2];
            pattern_reg   <= pattern;
            frame_end_reg <= (ntc_reg == tw - 11'd1) && (ntr_reg == th - 11'd1);
        end
    end

    // line store, one source line of pixels
    bdb_ram #(
        .WIDTH (3 * P),
        .DEPTH (LIM)
    ) u_line_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (col_reg),
        .wdata (cur_reg),
        .re    (ram_re),
        .raddr (col_reg),
        .rdata (ram_rdata)
    );

    // shared position divider
    bdb_axis_map u_axis_map (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (map_req),
        .rsp   (map_rsp)
    );

    // neighbor selection: a zero weight lets the current pixel stand in
    assign c11 = ox_reg ? (oy_reg ? upl_reg : left_reg) : (oy_reg ? up_reg : cur_reg);
    assign c12 = ox_reg ? left_reg : cur_reg;
    assign c21 = oy_reg ? up_reg : cur_reg;

    assign lane_ctrl = '{start: lane_go, ny: ny_reg, th: th, nx: nx_reg, tw: tw};

    // one lerp lane per color channel, red in the top byte
    for (genvar k = 0; k < bdb_pkg::CHANNELS; k++)
    begin : g_lane
        localparam int SH = (bdb_pkg::CHANNELS - 1 - k) * P;
        bdb_lane u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (lane_ctrl),
            .p11   (c11[SH +: P]),
            .p12   (c12[SH +: P]),
            .p21   (c21[SH +: P]),
            .p22   (cur_reg[SH +: P]),
            .done  (lane_done[k]),
            .res   (lane_res[k])
        );
    end

    // merge: channel average against the binarize level
    bdb_merge u_merge (
        .red     (lane_res[0]),
        .green   (lane_res[1]),
        .blue    (lane_res[2]),
        .level   (level_reg),
        .pattern (pattern)
    );

    assign res_out.valid       = out_valid_reg;
    assign res_out.red_out     = red_reg;
    assign res_out.green_out   = green_reg;
    assign res_out.blue_out    = blue_reg;
    assign res_out.pattern_bit = pattern_reg;
    assign res_out.frame_end   = frame_end_reg;

endmodule

// ===== hdl/bdb_checker.sv =====
module bdb_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready
);

    // an accepted item keeps the input closed while the line store is read
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready ##1 !in_ready)
        else $error("input reopened during line store read");

    // a new result only appears while an item is being worked on
    a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !in_ready)
        else $error("result appeared while idle");

    // leaving reset: idle and empty
    a_reset_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> (!out_valid && in_ready))
        else $error("not idle after reset");

    // a stalled result is held
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped while stalled");

endmodule

bind bilinear_downscale_binarize bdb_checker u_bdb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pix_in.valid),
    .in_ready  (pix_in.ready),
    .out_valid (res_out.valid),
    .out_ready (res_out.ready)
);
